// ----- hw/rtl/trsr_pkg.sv -----
// Shared widths, constants and packed types of the triangle row span rasterizer.
// Used by the pipelined ratio unit and by the top level; no dependencies.
`timescale 1ns / 1ps

package trsr_pkg;

    localparam int COORD_W   = 40;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int QUOT_W    = COORD_W + 2;
    localparam int SUM_W     = QUOT_W + 1;
    localparam int ROW_W     = 23;
    localparam int SPAN_W    = 24;
    localparam int ZOOM_W    = 5;
    localparam int MAX_ZOOM  = 22;
    localparam int SPAN_MAX  = (2 ** (SPAN_W - 1)) - 1;
    localparam int SPAN_MIN  = -(2 ** (SPAN_W - 1));
    localparam int RATIO_LAT = COORD_W + 3;

    typedef struct packed {
        logic signed [COORD_W-1:0] x0;
        logic signed [COORD_W-1:0] y0;
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] y1;
        logic signed [DIFF_W-1:0]  dx;
        logic        [COORD_W-1:0] dy;
    } seg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x0;
        logic signed [DIFF_W-1:0]  dx;
        logic        [COORD_W-1:0] dy;
        logic        [COORD_W-1:0] t_left;
        logic        [COORD_W-1:0] t_right;
    } edge_job_t;

    typedef struct packed {
        edge_job_t                shr;
        logic signed [DIFF_W-1:0] cmp;
        logic                     shared;
        logic                     hit;
    } pair_job_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        edge_job_t        lng;
        pair_job_t        pair;
    } lead_side_t;

    typedef struct packed {
        logic signed [DIFF_W-1:0]  num;
        logic        [COORD_W-1:0] tval;
        logic        [COORD_W-1:0] den;
        logic signed [COORD_W-1:0] x0;
    } ratio_job_t;

    typedef struct packed {
        ratio_job_t left;
        ratio_job_t right;
    } pair_pick_t;

    typedef struct packed {
        logic [ROW_W-1:0]          row;
        logic                      hit1;
        logic                      hit2;
        logic signed [COORD_W-1:0] x0;
    } span_side_t;

endpackage

// ----- hw/rtl/trsr_ratio.sv -----
// Pipelined unit giving floor and ceil of num * tval / den, one bit of quotient per stage.
// Depends on trsr_pkg; carries a valid bit and a side word along with each request.
`timescale 1ns / 1ps

module trsr_ratio #(
    parameter int SIDE_W = 1
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  logic signed [trsr_pkg::DIFF_W-1:0]   num,
    input  logic        [trsr_pkg::COORD_W-1:0]  tval,
    input  logic        [trsr_pkg::COORD_W-1:0]  den,
    input  logic        [SIDE_W-1:0]             side_in,
    output logic                                 out_valid,
    output logic signed [trsr_pkg::QUOT_W-1:0]   out_floor,
    output logic signed [trsr_pkg::QUOT_W-1:0]   out_ceil,
    output logic        [SIDE_W-1:0]             side_out
);
    import trsr_pkg::*;

    localparam int HALF_W = COORD_W / 2;
    localparam int PROD_W = 2 * COORD_W;

    logic [COORD_W-1:0] num_abs;
    logic [COORD_W-1:0] ll_next, lh_next, hl_next, hh_next;

    logic               s1_valid_reg;
    logic               s1_neg_reg;
    logic [COORD_W-1:0] s1_ll_reg, s1_lh_reg, s1_hl_reg, s1_hh_reg;
    logic [COORD_W-1:0] s1_den_reg;
    logic [SIDE_W-1:0]  s1_side_reg;

    logic [PROD_W-1:0]  prod_next;

    logic               dv_valid_reg [COORD_W+1];
    logic               dv_neg_reg   [COORD_W+1];
    logic [COORD_W-1:0] dv_rem_reg   [COORD_W+1];
    logic [COORD_W-1:0] dv_word_reg  [COORD_W+1];
    logic [COORD_W-1:0] dv_den_reg   [COORD_W+1];
    logic [SIDE_W-1:0]  dv_side_reg  [COORD_W+1];

    logic signed [QUOT_W-1:0] q_ext, nz_ext, floor_next, ceil_next;

    assign num_abs = num[DIFF_W-1] ? COORD_W'(-num) : COORD_W'(num);
    assign ll_next = COORD_W'(num_abs[HALF_W-1:0] * tval[HALF_W-1:0]);
    assign lh_next = COORD_W'(num_abs[HALF_W-1:0] * tval[COORD_W-1:HALF_W]);
    assign hl_next = COORD_W'(num_abs[COORD_W-1:HALF_W] * tval[HALF_W-1:0]);
    assign hh_next = COORD_W'(num_abs[COORD_W-1:HALF_W] * tval[COORD_W-1:HALF_W]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_neg_reg  <= num[DIFF_W-1];
            s1_ll_reg   <= ll_next;
            s1_lh_reg   <= lh_next;
            s1_hl_reg   <= hl_next;
            s1_hh_reg   <= hh_next;
            s1_den_reg  <= den;
            s1_side_reg <= side_in;
        end
    end

    assign prod_next = {s1_hh_reg, s1_ll_reg}
                     + (PROD_W'(s1_lh_reg) << HALF_W)
                     + (PROD_W'(s1_hl_reg) << HALF_W);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            dv_valid_reg[0] <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_neg_reg[0]  <= s1_neg_reg;
            dv_rem_reg[0]  <= prod_next[PROD_W-1:COORD_W];
            dv_word_reg[0] <= prod_next[COORD_W-1:0];
            dv_den_reg[0]  <= s1_den_reg;
            dv_side_reg[0] <= s1_side_reg;
        end
    end

    for (genvar j = 0; j < COORD_W; j++)
    begin : g_step
        logic [COORD_W:0] trial;
        logic             fits;

        assign trial = {dv_rem_reg[j], dv_word_reg[j][COORD_W-1]};
        assign fits  = trial >= {1'b0, dv_den_reg[j]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid_reg[j+1] <= 1'b0;
            end
            else if (en)
            begin
                dv_valid_reg[j+1] <= dv_valid_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_rem_reg[j+1]  <= fits ? COORD_W'(trial - {1'b0, dv_den_reg[j]})
                                         : trial[COORD_W-1:0];
                dv_word_reg[j+1] <= {dv_word_reg[j][COORD_W-2:0], fits};
                dv_neg_reg[j+1]  <= dv_neg_reg[j];
                dv_den_reg[j+1]  <= dv_den_reg[j];
                dv_side_reg[j+1] <= dv_side_reg[j];
            end
        end
    end

    assign q_ext      = signed'(QUOT_W'(dv_word_reg[COORD_W]));
    assign nz_ext     = signed'(QUOT_W'(|dv_rem_reg[COORD_W]));
    assign floor_next = dv_neg_reg[COORD_W] ? (-q_ext - nz_ext) : q_ext;
    assign ceil_next  = dv_neg_reg[COORD_W] ? (-q_ext) : (q_ext + nz_ext);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (en)
        begin
            out_valid <= dv_valid_reg[COORD_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_floor <= floor_next;
            out_ceil  <= ceil_next;
            side_out  <= dv_side_reg[COORD_W];
        end
    end

    // The floor and ceil of one quotient differ by at most one.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_ceil == out_floor)
                   || (out_ceil == out_floor + signed'(QUOT_W'(1))))
        else $error("ratio floor and ceil disagree");

    // The product never exceeds den times the quotient range, so the first remainder is below den.
    assert property (@(posedge clk) disable iff (!rst_n)
        (dv_valid_reg[0] && (dv_den_reg[0] != '0)) |-> (dv_rem_reg[0] < dv_den_reg[0]))
        else $error("ratio quotient overflows its width");

    // A held pipeline keeps its output valid bit.
    assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(out_valid))
        else $error("ratio pipeline moved while held");

endmodule

// ----- hw/rtl/triangle_row_span_rasterizer_top.sv -----
// Top level of the triangle row span rasterizer: edge setup, sorting, pair tests and span ends.
// Depends on trsr_pkg and on the pipelined ratio unit trsr_ratio.
`timescale 1ns / 1ps

// One request enters per cycle while s_tready is high, and its spans reach the output register
// through two ratio units in series, each giving one quotient bit per stage, 43 stages apiece,
// plus edge setup, sort, pair test, edge choice and rounding stages. A request whose row is
// covered by both edge pairs gives two output beats, one per span, with m_tlast on the second;
// a request that covers nothing gives no output. The user must write the zoom register only
// while the block holds no request; the block itself does not enforce this.
module triangle_row_span_rasterizer_top #(
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [trsr_pkg::ZOOM_W-1:0]  cfg_wr_data,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // vert_a_x, vert_a_y, vert_b_x, vert_b_y, vert_c_x, vert_c_y, row_index, one zero bit.
    input  logic [263:0]                 s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // span_left, span_right, span_row, one zero bit.
    output logic [71:0]                  m_tdata,
    output logic                         m_tlast
);
    import trsr_pkg::*;

    localparam int RT_W      = ROW_W + 1 + COORD_FRAC_BITS;
    localparam int T_W       = ((RT_W > COORD_W) ? RT_W : COORD_W) + 1;
    localparam int FRAC_MASK = (1 << COORD_FRAC_BITS) - 1;

    function automatic seg_t seg_make(input logic signed [COORD_W-1:0] ax,
                                      input logic signed [COORD_W-1:0] ay,
                                      input logic signed [COORD_W-1:0] bx,
                                      input logic signed [COORD_W-1:0] by);
        seg_t s;
        if (ay > by)
        begin
            s.x0 = bx;
            s.y0 = by;
            s.x1 = ax;
            s.y1 = ay;
        end
        else
        begin
            s.x0 = ax;
            s.y0 = ay;
            s.x1 = bx;
            s.y1 = by;
        end
        s.dx = DIFF_W'(s.x1) - DIFF_W'(s.x0);
        s.dy = COORD_W'(DIFF_W'(s.y1) - DIFF_W'(s.y0));
        return s;
    endfunction

    function automatic logic [COORD_W-1:0] clamp_t(input logic [ROW_W-1:0] row,
                                                   input logic nxt,
                                                   input logic signed [COORD_W-1:0] y0,
                                                   input logic [COORD_W-1:0] dy);
        logic [RT_W-1:0]       rs;
        logic signed [T_W-1:0] tv;
        rs = (RT_W'(row) + RT_W'(nxt)) << COORD_FRAC_BITS;
        tv = signed'(T_W'(rs)) - T_W'(y0);
        if (tv < 0)
        begin
            return '0;
        end
        else if (tv > signed'(T_W'(dy)))
        begin
            return dy;
        end
        return COORD_W'(tv);
    endfunction

    function automatic edge_job_t edge_job(input seg_t e, input logic [ROW_W-1:0] row);
        edge_job_t j;
        logic      neg;
        logic      pos;
        neg = e.dx[DIFF_W-1];
        pos = !neg && (e.dx != '0);
        j.x0      = e.x0;
        j.dx      = e.dx;
        j.dy      = e.dy;
        j.t_left  = clamp_t(row, neg, e.y0, e.dy);
        j.t_right = clamp_t(row, pos, e.y0, e.dy);
        return j;
    endfunction

    function automatic pair_job_t pair_prep(input seg_t lng, input seg_t shr,
                                            input logic [ROW_W-1:0] row,
                                            input logic [ROW_W-1:0] tiles);
        pair_job_t                 p;
        logic signed [COORD_W-1:0] top_fl;
        logic signed [DIFF_W-1:0]  bot_cl;
        logic signed [DIFF_W-1:0]  row_s;
        top_fl = shr.y0 >>> COORD_FRAC_BITS;
        bot_cl = (DIFF_W'(shr.y1) + signed'(DIFF_W'(FRAC_MASK))) >>> COORD_FRAC_BITS;
        row_s  = signed'(DIFF_W'(row));
        p.hit    = (shr.dy != '0) && (row_s >= DIFF_W'(top_fl)) && (row <= tiles)
                && (row_s <= bot_cl);
        p.shared = (lng.x0 == shr.x0) && (lng.y0 == shr.y0);
        p.cmp    = p.shared ? (DIFF_W'(shr.x1) - DIFF_W'(lng.x0))
                            : (DIFF_W'(lng.x1) - DIFF_W'(shr.x0));
        p.shr    = edge_job(shr, row);
        return p;
    endfunction

    function automatic pair_pick_t pair_pick(input pair_job_t pj, input edge_job_t lng,
                                             input logic signed [QUOT_W-1:0] fl,
                                             input logic signed [QUOT_W-1:0] cl);
        pair_pick_t k;
        edge_job_t  le;
        edge_job_t  re;
        logic       sw;
        sw = pj.shared ? (fl < QUOT_W'(pj.cmp)) : (QUOT_W'(pj.cmp) < cl);
        le = sw ? lng : pj.shr;
        re = sw ? pj.shr : lng;
        k.left.num   = le.dx;
        k.left.tval  = le.t_left;
        k.left.den   = le.dy;
        k.left.x0    = le.x0;
        k.right.num  = re.dx;
        k.right.tval = re.t_right;
        k.right.den  = re.dy;
        k.right.x0   = re.x0;
        return k;
    endfunction

    function automatic logic [SPAN_W-1:0] span_sat(input logic signed [SUM_W-1:0] s);
        if (s > signed'(SUM_W'(SPAN_MAX)))
        begin
            return SPAN_W'(SPAN_MAX);
        end
        else if (s < signed'(SUM_W'(SPAN_MIN)))
        begin
            return SPAN_W'(SPAN_MIN);
        end
        return s[SPAN_W-1:0];
    endfunction

    function automatic logic [SPAN_W-1:0] span_floor(input logic signed [COORD_W-1:0] x0,
                                                     input logic signed [QUOT_W-1:0] fl);
        logic signed [SUM_W-1:0] v;
        v = SUM_W'(x0) + SUM_W'(fl);
        return span_sat(v >>> COORD_FRAC_BITS);
    endfunction

    function automatic logic [SPAN_W-1:0] span_ceil(input logic signed [COORD_W-1:0] x0,
                                                    input logic signed [QUOT_W-1:0] cl);
        logic signed [SUM_W-1:0] v;
        v = SUM_W'(x0) + SUM_W'(cl) + signed'(SUM_W'(FRAC_MASK));
        return span_sat(v >>> COORD_FRAC_BITS);
    endfunction

    logic                adv;
    logic [ZOOM_W-1:0]   zoom_reg;
    logic [ZOOM_W-1:0]   zoom_eff;
    logic [ROW_W-1:0]    tiles;

    logic signed [COORD_W-1:0] in_ax, in_ay, in_bx, in_by, in_cx, in_cy;
    logic [ROW_W-1:0]          in_row;

    logic             a_valid_reg;
    logic [ROW_W-1:0] a_row_reg;
    seg_t             a_ab_reg, a_bc_reg, a_ca_reg;

    seg_t             b_e0_next, b_e1_next, b_e2_next, b_tmp0, b_tmp1;
    logic             b_valid_reg;
    logic [ROW_W-1:0] b_row_reg;
    seg_t             b_e0_reg, b_e1_reg, b_e2_reg;

    logic             c_valid_reg;
    logic [ROW_W-1:0] c_row_reg;
    seg_t             c_sh1_reg, c_sh2_reg, c_lng_reg;

    logic             p_valid_reg;
    lead_side_t       p_side1_next, p_side1_reg;
    pair_job_t        p_side2_reg;

    logic                     r1_valid, r2_valid;
    logic signed [QUOT_W-1:0] r1_fl, r1_cl, r2_fl, r2_cl;
    logic [$bits(lead_side_t)-1:0] r1_side;
    logic [$bits(pair_job_t)-1:0]  r2_side;
    lead_side_t               r1_lead;
    pair_job_t                r2_pair;

    logic             d_valid_reg;
    logic [ROW_W-1:0] d_row_reg;
    logic             d_hit1_reg, d_hit2_reg;
    pair_pick_t       d_pick1_reg, d_pick2_reg;
    span_side_t       d_side_l1;

    logic                     q_l1_valid, q_r1_valid, q_l2_valid, q_r2_valid;
    logic signed [QUOT_W-1:0] q_l1_fl, q_l1_cl, q_r1_fl, q_r1_cl;
    logic signed [QUOT_W-1:0] q_l2_fl, q_l2_cl, q_r2_fl, q_r2_cl;
    logic [$bits(span_side_t)-1:0] q_l1_side;
    logic [COORD_W-1:0]       q_r1_side, q_l2_side, q_r2_side;
    span_side_t               q_l1_info;

    logic             e_valid_reg, e_hit1_reg, e_hit2_reg;
    logic [ROW_W-1:0] e_row_reg;
    logic [SPAN_W-1:0] e_l1_reg, e_r1_reg, e_l2_reg, e_r2_reg;

    logic              ob_valid_reg, ob_pend_reg;
    logic [ROW_W-1:0]  ob_row_reg;
    logic [SPAN_W-1:0] ob_left_reg, ob_right_reg, ob_next_left_reg, ob_next_right_reg;
    logic              ob_load;

    assign in_ax  = signed'(s_tdata[39:0]);
    assign in_ay  = signed'(s_tdata[79:40]);
    assign in_bx  = signed'(s_tdata[119:80]);
    assign in_by  = signed'(s_tdata[159:120]);
    assign in_cx  = signed'(s_tdata[199:160]);
    assign in_cy  = signed'(s_tdata[239:200]);
    assign in_row = s_tdata[262:240];

    assign adv = !e_valid_reg || !(e_hit1_reg || e_hit2_reg) || !ob_valid_reg
              || (m_tready && !ob_pend_reg);
    assign s_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zoom_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            zoom_reg <= cfg_wr_data;
        end
    end

    assign zoom_eff = (zoom_reg > ZOOM_W'(MAX_ZOOM)) ? ZOOM_W'(MAX_ZOOM) : zoom_reg;
    assign tiles    = ROW_W'(1) << zoom_eff;

    always_comb
    begin
        b_e0_next = a_ab_reg;
        b_tmp0    = a_bc_reg;
        b_e2_next = a_ca_reg;
        if (b_e0_next.dy > b_tmp0.dy)
        begin
            b_e0_next = a_bc_reg;
            b_tmp0    = a_ab_reg;
        end
        b_tmp1 = b_e0_next;
        if (b_tmp1.dy > b_e2_next.dy)
        begin
            b_e0_next = b_e2_next;
            b_e2_next = b_tmp1;
        end
        b_e1_next = b_tmp0;
    end

    assign p_side1_next.row  = c_row_reg;
    assign p_side1_next.lng  = edge_job(c_lng_reg, c_row_reg);
    assign p_side1_next.pair = pair_prep(c_lng_reg, c_sh1_reg, c_row_reg, tiles);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            p_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= s_tvalid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            p_valid_reg <= c_valid_reg;
            d_valid_reg <= r1_valid;
            e_valid_reg <= q_l1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_row_reg <= in_row;
            a_ab_reg  <= seg_make(in_ax, in_ay, in_bx, in_by);
            a_bc_reg  <= seg_make(in_bx, in_by, in_cx, in_cy);
            a_ca_reg  <= seg_make(in_cx, in_cy, in_ax, in_ay);

            b_row_reg <= a_row_reg;
            b_e0_reg  <= b_e0_next;
            b_e1_reg  <= b_e1_next;
            b_e2_reg  <= b_e2_next;

            c_row_reg <= b_row_reg;
            c_sh1_reg <= b_e0_reg;
            if (b_e1_reg.dy > b_e2_reg.dy)
            begin
                c_sh2_reg <= b_e2_reg;
                c_lng_reg <= b_e1_reg;
            end
            else
            begin
                c_sh2_reg <= b_e1_reg;
                c_lng_reg <= b_e2_reg;
            end

            p_side1_reg <= p_side1_next;
            p_side2_reg <= pair_prep(c_lng_reg, c_sh2_reg, c_row_reg, tiles);
        end
    end

    trsr_ratio #(
        .SIDE_W ($bits(lead_side_t))
    ) u_order1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (p_valid_reg),
        .num       (p_side1_reg.lng.dx),
        .tval      (p_side1_reg.pair.shr.dy),
        .den       (p_side1_reg.lng.dy),
        .side_in   (p_side1_reg),
        .out_valid (r1_valid),
        .out_floor (r1_fl),
        .out_ceil  (r1_cl),
        .side_out  (r1_side)
    );

    trsr_ratio #(
        .SIDE_W ($bits(pair_job_t))
    ) u_order2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (p_valid_reg),
        .num       (p_side1_reg.lng.dx),
        .tval      (p_side2_reg.shr.dy),
        .den       (p_side1_reg.lng.dy),
        .side_in   (p_side2_reg),
        .out_valid (r2_valid),
        .out_floor (r2_fl),
        .out_ceil  (r2_cl),
        .side_out  (r2_side)
    );

    assign r1_lead = lead_side_t'(r1_side);
    assign r2_pair = pair_job_t'(r2_side);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_row_reg   <= r1_lead.row;
            d_hit1_reg  <= r1_lead.pair.hit;
            d_hit2_reg  <= r2_pair.hit;
            d_pick1_reg <= pair_pick(r1_lead.pair, r1_lead.lng, r1_fl, r1_cl);
            d_pick2_reg <= pair_pick(r2_pair, r1_lead.lng, r2_fl, r2_cl);
        end
    end

    assign d_side_l1.row  = d_row_reg;
    assign d_side_l1.hit1 = d_hit1_reg;
    assign d_side_l1.hit2 = d_hit2_reg;
    assign d_side_l1.x0   = d_pick1_reg.left.x0;

    trsr_ratio #(
        .SIDE_W ($bits(span_side_t))
    ) u_left1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (d_valid_reg),
        .num       (d_pick1_reg.left.num),
        .tval      (d_pick1_reg.left.tval),
        .den       (d_pick1_reg.left.den),
        .side_in   (d_side_l1),
        .out_valid (q_l1_valid),
        .out_floor (q_l1_fl),
        .out_ceil  (q_l1_cl),
        .side_out  (q_l1_side)
    );

    trsr_ratio #(
        .SIDE_W (COORD_W)
    ) u_right1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (d_valid_reg),
        .num       (d_pick1_reg.right.num),
        .tval      (d_pick1_reg.right.tval),
        .den       (d_pick1_reg.right.den),
        .side_in   (d_pick1_reg.right.x0),
        .out_valid (q_r1_valid),
        .out_floor (q_r1_fl),
        .out_ceil  (q_r1_cl),
        .side_out  (q_r1_side)
    );

    trsr_ratio #(
        .SIDE_W (COORD_W)
    ) u_left2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (d_valid_reg),
        .num       (d_pick2_reg.left.num),
        .tval      (d_pick2_reg.left.tval),
        .den       (d_pick2_reg.left.den),
        .side_in   (d_pick2_reg.left.x0),
        .out_valid (q_l2_valid),
        .out_floor (q_l2_fl),
        .out_ceil  (q_l2_cl),
        .side_out  (q_l2_side)
    );

    trsr_ratio #(
        .SIDE_W (COORD_W)
    ) u_right2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (d_valid_reg),
        .num       (d_pick2_reg.right.num),
        .tval      (d_pick2_reg.right.tval),
        .den       (d_pick2_reg.right.den),
        .side_in   (d_pick2_reg.right.x0),
        .out_valid (q_r2_valid),
        .out_floor (q_r2_fl),
        .out_ceil  (q_r2_cl),
        .side_out  (q_r2_side)
    );

    assign q_l1_info = span_side_t'(q_l1_side);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_hit1_reg <= q_l1_info.hit1;
            e_hit2_reg <= q_l1_info.hit2;
            e_row_reg  <= q_l1_info.row;
            e_l1_reg   <= span_floor(q_l1_info.x0, q_l1_fl);
            e_r1_reg   <= span_ceil(signed'(q_r1_side), q_r1_cl);
            e_l2_reg   <= span_floor(signed'(q_l2_side), q_l2_fl);
            e_r2_reg   <= span_ceil(signed'(q_r2_side), q_r2_cl);
        end
    end

    assign ob_load = adv && e_valid_reg && (e_hit1_reg || e_hit2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ob_valid_reg <= 1'b0;
            ob_pend_reg  <= 1'b0;
        end
        else if (ob_load)
        begin
            ob_valid_reg <= 1'b1;
            ob_pend_reg  <= e_hit1_reg && e_hit2_reg;
        end
        else if (ob_valid_reg && m_tready)
        begin
            ob_valid_reg <= ob_pend_reg;
            ob_pend_reg  <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ob_load)
        begin
            ob_row_reg        <= e_row_reg;
            ob_left_reg       <= e_hit1_reg ? e_l1_reg : e_l2_reg;
            ob_right_reg      <= e_hit1_reg ? e_r1_reg : e_r2_reg;
            ob_next_left_reg  <= e_l2_reg;
            ob_next_right_reg <= e_r2_reg;
        end
        else if (ob_valid_reg && m_tready && ob_pend_reg)
        begin
            ob_left_reg  <= ob_next_left_reg;
            ob_right_reg <= ob_next_right_reg;
        end
    end

    assign m_tvalid = ob_valid_reg;
    assign m_tlast  = !ob_pend_reg;
    assign m_tdata  = {1'b0, ob_row_reg, ob_right_reg, ob_left_reg};

    // The two ordering units run in lockstep.
    assert property (@(posedge clk) disable iff (!rst_n)
        r1_valid == r2_valid)
        else $error("ordering units out of step");

    // The four span-end units run in lockstep.
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_l1_valid == q_r1_valid) && (q_l1_valid == q_l2_valid)
        && (q_l1_valid == q_r2_valid))
        else $error("span end units out of step");

    // A pending second span only exists behind a shown first span.
    assert property (@(posedge clk) disable iff (!rst_n)
        ob_pend_reg |-> ob_valid_reg)
        else $error("second span pending without a first");

    // After a non-final span is taken, the final span of the same request follows.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=> (m_tvalid && m_tlast))
        else $error("second span missing");

    // An empty last stage never blocks new requests.
    assert property (@(posedge clk) disable iff (!rst_n)
        !e_valid_reg |-> s_tready)
        else $error("input stalled with room in the pipeline");

endmodule
